FILE: rtl/ows_pkg.sv
// Shared constants and CRC-8 helper functions for the 1-Wire search-ROM engine.
package ows_pkg;

    localparam int unsigned OWS_ROM_BYTES    = 8;
    localparam logic [7:0]  OWS_CRC_POLY     = 8'h8C;
    localparam int unsigned OWS_FAMILY_LIMIT = 9;

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BITS  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // CRC-8 (reflected) of a message of nbits bits that holds a single one at bit i.
    function automatic logic [7:0] crc8_onehot(int unsigned i, int unsigned nbits);
        logic [7:0] crc;
        logic       mix;
        crc = 8'h00;
        for (int unsigned k = 0; k < nbits; k++)
        begin
            mix = crc[0] ^ (k == i);
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ OWS_CRC_POLY;
            end
        end
        return crc;
    endfunction

    // Message bits that feed CRC output bit j; the CRC is linear, so each bit
    // is the parity of the message bits under this mask.
    function automatic logic [63:0] crc8_mask(int unsigned j, int unsigned data_bytes);
        logic [63:0] mask;
        logic [7:0]  col;
        mask = '0;
        for (int unsigned i = 0; i < data_bytes * 8; i++)
        begin
            col     = crc8_onehot(i, data_bytes * 8);
            mask[i] = col[j];
        end
        return mask;
    endfunction

endpackage

FILE: rtl/onewire_rom_search_top.sv
// Search-ROM engine of a 1-Wire bus master: branch selection, discrepancy tracking, CRC check.
//
// Usage: the request channel (req_valid / req_stall) carries one item per transfer:
// a begin request with the presence result, a sampled bit pair with its complement,
// or a request to clear the enumeration state. The response channel
// (rsp_valid / rsp_stall) returns exactly one result per request, in order.
// A begin answers with send_search_cmd (the master then sends the search command),
// each bit pair answers with the direction bit to write, and the last bit of a pass
// reports the ROM id, found, last_found and the CRC check of the id.
//
// A request passes through one input register and one result register, with the branch
// logic between them. Throughput is one item per cycle while the response is not stalled.
// A stalled response holds the result register; the input register still takes one
// more item, and req_stall rises only when both registers are full.
// Reset (asynchronous, active low) empties both registers and returns the search
// state to its start: no discrepancies, ROM bits zero, bit position one.
module onewire_rom_search_top
    import ows_pkg::*;
#(
    parameter int unsigned ROM_BYTES = OWS_ROM_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [1:0]             req_type,
    input  logic                   presence,
    input  logic                   id_bit,
    input  logic                   cmp_bit,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   send_search_cmd,
    output logic                   write_valid,
    output logic                   write_bit,
    output logic                   pass_done,
    output logic                   found,
    output logic [ROM_BYTES*8-1:0] rom_id,
    output logic                   last_found,
    output logic                   rom_crc_ok,
    output logic [3:0]             family_branch
);

    localparam int unsigned TOTAL_BITS = ROM_BYTES * 8;
    localparam int unsigned DATA_BITS  = TOTAL_BITS - 8;
    localparam int unsigned PW         = $clog2(TOTAL_BITS + 1);
    localparam int unsigned IW         = $clog2(TOTAL_BITS);

    // Input register.
    logic       in_valid_reg;
    logic [1:0] in_type_reg;
    logic       in_presence_reg;
    logic       in_id_reg;
    logic       in_cmp_reg;

    // Search state.
    logic [TOTAL_BITS-1:0] rom_reg,         rom_next;
    logic [PW-1:0]         last_branch_reg, last_branch_next;
    logic [3:0]            fam_branch_reg,  fam_branch_next;
    logic                  no_more_reg,     no_more_next;
    logic [PW-1:0]         pos_reg,         pos_next;
    logic [PW-1:0]         last_zero_reg,   last_zero_next;
    logic                  in_pass_reg,     in_pass_next;

    // Result register.
    logic                  out_valid_reg;
    logic                  send_reg,  send_next;
    logic                  wvalid_reg, wvalid_next;
    logic                  wbit_reg,  wbit_next;
    logic                  done_reg,  done_next;
    logic                  found_reg, found_next;
    logic [TOTAL_BITS-1:0] rom_out_reg;
    logic                  last_reg;
    logic                  crc_ok_reg, crc_ok_next;
    logic [3:0]            fam_out_reg;

    logic          advance;
    logic          process;
    logic [PW-1:0] pos_dec;
    logic [IW-1:0] idx;
    logic          dir;
    logic [7:0]    crc;

    assign advance   = !out_valid_reg || !rsp_stall;
    assign process   = in_valid_reg && advance;
    assign req_stall = in_valid_reg && !advance;
    assign pos_dec   = pos_reg - PW'(1);
    assign idx       = pos_dec[IW-1:0];

    always_comb
    begin
        rom_next         = rom_reg;
        last_branch_next = last_branch_reg;
        fam_branch_next  = fam_branch_reg;
        no_more_next     = no_more_reg;
        pos_next         = pos_reg;
        last_zero_next   = last_zero_reg;
        in_pass_next     = in_pass_reg;
        send_next        = 1'b0;
        wvalid_next      = 1'b0;
        wbit_next        = 1'b0;
        done_next        = 1'b0;
        found_next       = 1'b0;
        dir              = 1'b0;
        unique case (in_type_reg)
            REQ_BEGIN:
            begin
                if (no_more_reg || !in_presence_reg)
                begin
                    last_branch_next = '0;
                    fam_branch_next  = '0;
                    no_more_next     = 1'b0;
                    in_pass_next     = 1'b0;
                    done_next        = 1'b1;
                end
                else
                begin
                    in_pass_next   = 1'b1;
                    pos_next       = PW'(1);
                    last_zero_next = '0;
                    send_next      = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                rom_next         = '0;
                last_branch_next = '0;
                fam_branch_next  = '0;
                no_more_next     = 1'b0;
                pos_next         = PW'(1);
                last_zero_next   = '0;
                in_pass_next     = 1'b0;
            end
            REQ_BITS:
            begin
                if (in_pass_reg)
                begin
                    if (in_id_reg && in_cmp_reg)
                    begin
                        // Nobody answered this position: abort the pass.
                        last_branch_next = '0;
                        fam_branch_next  = '0;
                        no_more_next     = 1'b0;
                        in_pass_next     = 1'b0;
                        done_next        = 1'b1;
                    end
                    else
                    begin
                        if (in_id_reg != in_cmp_reg)
                        begin
                            dir = in_id_reg;
                        end
                        else
                        begin
                            // Discrepancy: follow the previous path below the last
                            // branch, take the one branch at it, zero beyond it.
                            if (pos_reg < last_branch_reg)
                            begin
                                dir = rom_reg[idx];
                            end
                            else
                            begin
                                dir = (pos_reg == last_branch_reg);
                            end
                            if (!dir)
                            begin
                                last_zero_next = pos_reg;
                                if (pos_reg < PW'(OWS_FAMILY_LIMIT))
                                begin
                                    fam_branch_next = pos_reg[3:0];
                                end
                            end
                        end
                        rom_next[idx] = dir;
                        wvalid_next   = 1'b1;
                        wbit_next     = dir;
                        if (pos_reg >= PW'(TOTAL_BITS))
                        begin
                            in_pass_next     = 1'b0;
                            done_next        = 1'b1;
                            last_branch_next = last_zero_next;
                            pos_next         = PW'(1);
                            if (last_zero_next == '0)
                            begin
                                no_more_next = 1'b1;
                            end
                            if (rom_next[7:0] == 8'h00)
                            begin
                                last_branch_next = '0;
                                fam_branch_next  = '0;
                                no_more_next     = 1'b0;
                                in_pass_next     = 1'b0;
                            end
                            else
                            begin
                                found_next = 1'b1;
                            end
                        end
                        else
                        begin
                            pos_next = pos_reg + PW'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Each CRC bit is the parity of a fixed set of data bits.
    for (genvar j = 0; j < 8; j++)
    begin : g_crc
        localparam logic [63:0] MASK = crc8_mask(j, ROM_BYTES - 1);
        assign crc[j] = ^(rom_next[DATA_BITS-1:0] & MASK[DATA_BITS-1:0]);
    end

    assign crc_ok_next = (crc == rom_next[TOTAL_BITS-1 -: 8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_type_reg     <= req_type;
            in_presence_reg <= presence;
            in_id_reg       <= id_bit;
            in_cmp_reg      <= cmp_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg         <= '0;
            last_branch_reg <= '0;
            fam_branch_reg  <= '0;
            no_more_reg     <= 1'b0;
            pos_reg         <= PW'(1);
            last_zero_reg   <= '0;
            in_pass_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                rom_reg         <= rom_next;
                last_branch_reg <= last_branch_next;
                fam_branch_reg  <= fam_branch_next;
                no_more_reg     <= no_more_next;
                pos_reg         <= pos_next;
                last_zero_reg   <= last_zero_next;
                in_pass_reg     <= in_pass_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            send_reg    <= send_next;
            wvalid_reg  <= wvalid_next;
            wbit_reg    <= wbit_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            rom_out_reg <= rom_next;
            last_reg    <= done_next && no_more_next;
            crc_ok_reg  <= crc_ok_next;
            fam_out_reg <= fam_branch_next;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign send_search_cmd = send_reg;
    assign write_valid     = wvalid_reg;
    assign write_bit       = wbit_reg;
    assign pass_done       = done_reg;
    assign found           = found_reg;
    assign rom_id          = rom_out_reg;
    assign last_found      = last_reg;
    assign rom_crc_ok      = crc_ok_reg;
    assign family_branch   = fam_out_reg;

endmodule

FILE: rtl/ows_chk.sv
// Port-level assertions for the search-ROM engine and their binding to the top level.
module ows_chk
    import ows_pkg::*;
#(
    parameter int unsigned ROM_BYTES = OWS_ROM_BYTES
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_stall,
    input logic [1:0]             req_type,
    input logic                   presence,
    input logic                   id_bit,
    input logic                   cmp_bit,
    input logic                   rsp_valid,
    input logic                   rsp_stall,
    input logic                   send_search_cmd,
    input logic                   write_valid,
    input logic                   write_bit,
    input logic                   pass_done,
    input logic                   found,
    input logic [ROM_BYTES*8-1:0] rom_id,
    input logic                   last_found,
    input logic                   rom_crc_ok,
    input logic [3:0]             family_branch
);

    // A stalled response keeps its transfer and its ROM id.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rom_id) && $stable(found))
        else $error("stalled response changed");

    // A begin response never asks for a bus write.
    a_begin_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && send_search_cmd |-> !write_valid && !pass_done)
        else $error("begin response carries a write or end of pass");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (found || last_found) |-> pass_done)
        else $error("found or last_found outside the end of a pass");

    // A found device always has a nonzero family byte and was written this item.
    a_found_family: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> rom_id[7:0] != 8'h00 && write_valid)
        else $error("found with zero family byte");

    a_family_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> family_branch < 4'd9)
        else $error("family branch out of range");

endmodule

bind onewire_rom_search_top ows_chk #(.ROM_BYTES(ROM_BYTES)) u_ows_chk (.*);
